// ===== design/compacting_value_list_assert.svh =====
// Assertion macros used by the verification module of the value list block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef COMPACTING_VALUE_LIST_ASSERT_SVH
`define COMPACTING_VALUE_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CVL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CVL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cvl_pkg.sv =====
// Package for the compacting value list: request and result payload types,
// request kinds, result status codes, controller states and control structs.
// No dependencies.
`default_nettype none

package cvl_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 3;

    // Request kinds.
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ADDED      = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_DELETED    = 3'd2;
    localparam logic [2:0] ST_EMPTY_DEL  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_ENTRY      = 3'd5;
    localparam logic [2:0] ST_LIST_EMPTY = 3'd6;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]              status;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] entry_value;
        logic                    final_res;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DEL_READ,
        S_DEL_CMP,
        S_SHIFT_READ,
        S_SHIFT_WRITE,
        S_DEL_DONE,
        S_NOT_FOUND,
        S_LIST_READ,
        S_LIST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_next;
        logic       wr_append;
        logic       wr_shift;
        logic       pos_save;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       emit;
        logic [2:0] emit_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_kind;
        logic       count_zero;
        logic       full;
        logic       match;
        logic       idx_last;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/cvl_datapath.sv =====
// Datapath of the compacting value list: request register, entry memory,
// fill count, scan index and the result output register.
// Depends on cvl_pkg.
`default_nettype none

module cvl_datapath #(
    parameter int DEPTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cvl_pkg::cmd_t    cmd,
    input  wire cvl_pkg::dp_cmd_t ctl,
    output cvl_pkg::dp_stat_t     stat,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output cvl_pkg::res_t         res
);
    import cvl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    logic [1:0]       req_kind_reg;
    logic [VAL_W-1:0] req_value_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    logic [CW-1:0]    idx_plus;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             wr_en;

    assign idx_plus = idx_reg + CW'(1);
    assign rd_addr  = ctl.rd_next ? idx_plus[AW-1:0] : idx_reg[AW-1:0];
    assign wr_en    = ctl.wr_append | ctl.wr_shift;
    assign wr_addr  = ctl.wr_append ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data  = ctl.wr_append ? req_value_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_kind_reg  <= cmd.kind;
            req_value_reg <= cmd.value;
        end
        if (ctl.pos_save)
        begin
            pos_reg <= idx_reg;
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (ctl.idx_clr)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_plus;
        end

        res_valid_next = res_valid_reg;
        if (ctl.emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Result payload; only loaded when the controller emits.
    always_comb
    begin
        res_next = res_reg;
        if (ctl.emit)
        begin
            res_next.status      = ctl.emit_status;
            res_next.position    = '0;
            res_next.entry_value = req_value_reg;
            res_next.final_res   = 1'b1;
            case (ctl.emit_status)
                ST_ADDED:
                begin
                    res_next.position = POS_W'(count_reg);
                end
                ST_DELETED:
                begin
                    res_next.position = POS_W'(pos_reg);
                end
                ST_ENTRY:
                begin
                    res_next.position    = POS_W'(idx_reg);
                    res_next.entry_value = rd_data_reg;
                    res_next.final_res   = (idx_plus == count_reg);
                end
                ST_LIST_EMPTY:
                begin
                    res_next.entry_value = '0;
                end
                default:
                begin
                    res_next.position = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        stat.req_kind   = req_kind_reg;
        stat.count_zero = (count_reg == '0);
        stat.full       = (count_reg == CW'(DEPTH));
        stat.match      = (rd_data_reg == req_value_reg);
        stat.idx_last   = (idx_plus == count_reg);
        stat.out_free   = !res_valid_reg || !res_stall;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== design/cvl_ctrl.sv =====
// Controller of the compacting value list: sequences append, delete-and-shift
// and list requests over the datapath through command and status structs.
// Depends on cvl_pkg.
`default_nettype none

module cvl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire cvl_pkg::dp_stat_t stat,
    output cvl_pkg::dp_cmd_t       ctl
);
    import cvl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.req_kind)
                    KIND_APPEND:
                    begin
                        if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (!stat.count_zero)
                        begin
                            state_next = S_DEL_READ;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_LIST:
                    begin
                        if (!stat.count_zero)
                        begin
                            state_next = S_LIST_READ;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // The unused kind produces no result.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DEL_READ:
            begin
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_SHIFT_READ;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_NOT_FOUND;
                end
                else
                begin
                    state_next = S_DEL_READ;
                end
            end
            S_SHIFT_READ:
            begin
                state_next = stat.idx_last ? S_DEL_DONE : S_SHIFT_WRITE;
            end
            S_SHIFT_WRITE:
            begin
                state_next = S_SHIFT_READ;
            end
            S_DEL_DONE, S_NOT_FOUND:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LIST_READ:
            begin
                state_next = S_LIST_EMIT;
            end
            S_LIST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.idx_last ? S_IDLE : S_LIST_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        cmd_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                ctl.load_req = cmd_valid;
            end
            S_DECODE:
            begin
                case (stat.req_kind)
                    KIND_APPEND:
                    begin
                        if (stat.out_free)
                        begin
                            ctl.emit = 1'b1;
                            if (stat.full)
                            begin
                                ctl.emit_status = ST_FULL;
                            end
                            else
                            begin
                                ctl.emit_status = ST_ADDED;
                                ctl.wr_append   = 1'b1;
                                ctl.cnt_inc     = 1'b1;
                            end
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (!stat.count_zero)
                        begin
                            ctl.idx_clr = 1'b1;
                        end
                        else if (stat.out_free)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_EMPTY_DEL;
                        end
                    end
                    KIND_LIST:
                    begin
                        if (!stat.count_zero)
                        begin
                            ctl.idx_clr = 1'b1;
                        end
                        else if (stat.out_free)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_LIST_EMPTY;
                        end
                    end
                    default:
                    begin
                        ctl.emit = 1'b0;
                    end
                endcase
            end
            S_DEL_READ, S_LIST_READ:
            begin
                ctl.rd_en = 1'b1;
            end
            S_DEL_CMP:
            begin
                if (stat.match)
                begin
                    ctl.pos_save = 1'b1;
                end
                else if (!stat.idx_last)
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            S_SHIFT_READ:
            begin
                // Fetch the entry above the hole so it can move down one place.
                if (!stat.idx_last)
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_next = 1'b1;
                end
            end
            S_SHIFT_WRITE:
            begin
                ctl.wr_shift = 1'b1;
                ctl.idx_inc  = 1'b1;
            end
            S_DEL_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = ST_DELETED;
                    ctl.cnt_dec     = 1'b1;
                end
            end
            S_NOT_FOUND:
            begin
                if (stat.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = ST_NOT_FOUND;
                end
            end
            S_LIST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = ST_ENTRY;
                    ctl.idx_inc     = 1'b1;
                end
            end
            default:
            begin
                ctl.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/compacting_value_list.sv =====
// Compacting value list: an unsorted list of up to DEPTH signed 32-bit values.
// Requests arrive on cmd (cmd_valid/cmd_stall): kind 0 appends, kind 1 deletes
// the first equal entry and moves later entries down, kind 2 lists every entry.
// Kind 3 is dropped without a result. Results leave on res (res_valid/res_stall),
// one or more per request, the last one flagged by final_res.
// A request is taken only while the controller is idle; cmd_stall is high while
// it is being worked on. The result register decouples the output, so a new
// request may be taken while the last result still waits.
// Append and the single-result failures are resolved in the decode state. A
// delete reads and compares entries in turn until a match, then moves each later
// entry down with a read and a write before the result; a miss reports at the end
// of the scan. A list reads each entry and then emits it. The controller returns
// to idle as the last result is loaded and takes the next request from there.
// The entry memory has a registered read.
// A stalled receiver holds the result register, and the controller waits in
// place until it can load the next result, so nothing is lost or repeated.
// Reset clears the fill count (list empty), the controller and res_valid; the
// entry memory is not cleared, since only entries below the count are read.
`default_nettype none

module compacting_value_list #(
    parameter int DEPTH = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire cvl_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output cvl_pkg::res_t      res
);
    import cvl_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    cvl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    cvl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

// ===== design/cvl_checker.sv =====
// Port-level checker for the compacting value list, bound to the top level.
// Depends on cvl_pkg and compacting_value_list_assert.svh.
`default_nettype none

`include "compacting_value_list_assert.svh"

module cvl_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire cvl_pkg::res_t res
);
    import cvl_pkg::*;

    logic fail_status;
    logic empty_zero;

    assign fail_status = (res.status == ST_FULL) || (res.status == ST_EMPTY_DEL)
                         || (res.status == ST_NOT_FOUND);
    assign empty_zero  = (res.position == '0) && (res.entry_value == '0);

    `CVL_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "stalled result dropped")
    `CVL_ASSERT_NOW(a_single_final, res_valid && res.status != ST_ENTRY, res.final_res, "no final")
    `CVL_ASSERT_NOW(a_empty_zero, res_valid && res.status == ST_LIST_EMPTY, empty_zero, "not zero")
    `CVL_ASSERT_NOW(a_fail_pos, res_valid && fail_status, res.position == '0, "nonzero position")

endmodule

bind compacting_value_list cvl_checker u_cvl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the compacting value list: drives all four request kinds,
// predicts every result in a scoreboard class and compares field by field.
// Depends on cvl_pkg and the compacting_value_list RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cvl_pkg::*;

    localparam int LIST_DEPTH     = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 64;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    class list_scoreboard;
        logic signed [VAL_W-1:0] held [LIST_DEPTH];
        int unsigned held_count;
        res_t awaited [$];
        int unsigned mismatches;
        int unsigned requests_seen;
        int unsigned results_seen;
        int unsigned status_hits [7];

        function new();
            held_count = 0;
            mismatches = 0;
            requests_seen = 0;
            results_seen = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function void push_result(logic [2:0] status, int unsigned pos,
                                  logic signed [VAL_W-1:0] value, logic last);
            res_t r;
            r.status = status;
            r.position = POS_W'(pos);
            r.entry_value = value;
            r.final_res = last;
            awaited.push_back(r);
        endfunction

        function void note_request(cmd_t req);
            int unsigned hit;
            bit found;
            hit = 0;
            found = 1'b0;
            requests_seen++;
            case (req.kind)
                KIND_APPEND:
                begin
                    if (held_count == LIST_DEPTH)
                        push_result(ST_FULL, 0, req.value, 1'b1);
                    else
                    begin
                        held[held_count] = req.value;
                        push_result(ST_ADDED, held_count, req.value, 1'b1);
                        held_count++;
                    end
                end
                KIND_DELETE:
                begin
                    if (held_count == 0)
                        push_result(ST_EMPTY_DEL, 0, req.value, 1'b1);
                    else
                    begin
                        for (int i = 0; i < held_count; i++)
                        begin
                            if (!found && held[i] == req.value)
                            begin
                                hit = i;
                                found = 1'b1;
                            end
                        end
                        if (!found)
                            push_result(ST_NOT_FOUND, 0, req.value, 1'b1);
                        else
                        begin
                            // Later entries close the gap left by the removed one.
                            for (int i = hit; i + 1 < held_count; i++)
                                held[i] = held[i + 1];
                            held_count--;
                            push_result(ST_DELETED, hit, req.value, 1'b1);
                        end
                    end
                end
                KIND_LIST:
                begin
                    if (held_count == 0)
                        push_result(ST_LIST_EMPTY, 0, '0, 1'b1);
                    else
                        for (int i = 0; i < held_count; i++)
                            push_result(ST_ENTRY, i, held[i], i + 1 == held_count);
                end
                default:
                    ;
            endcase
        endfunction

        function void report(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d pos %0d %0h",
                         $time, got.status, got.position, got.entry_value);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            results_seen++;
            if (want.status <= ST_LIST_EMPTY)
                status_hits[want.status]++;
            if (got.status !== want.status)
                report("status", VAL_W'(want.status), VAL_W'(got.status));
            if (got.position !== want.position)
                report("position", VAL_W'(want.position), VAL_W'(got.position));
            if (got.entry_value !== want.entry_value)
                report("entry_value", want.entry_value, got.entry_value);
            if (got.final_res !== want.final_res)
                report("final_res", VAL_W'(want.final_res), VAL_W'(got.final_res));
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    list_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_start = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic signed [VAL_W-1:0] value_pool [6] = '{32'sd0, -32'sd1, 32'sd7, 32'sh7fff_ffff,
                                                 32'sh8000_0000, 32'sd42};

    compacting_value_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor and watchdog. Values sampled here are the ones before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                board.note_request(cmd);
            if (res_valid && !res_stall)
                board.check_result(res);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
                $display("[compacting_value_list] ERROR");
                $finish;
            end
        end
    end

    // Offers one request and returns at the edge where it is taken. Valid stays high so that
    // a following request can go out back to back.
    task automatic offer_request(input logic [1:0] kind, input logic signed [VAL_W-1:0] value);
        cmd_t req;
        req.kind = kind;
        req.value = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= req;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Deletes mostly aim at values that are in the list, so matches at every position occur.
    function automatic logic signed [VAL_W-1:0] pick_value(bit for_delete);
        int unsigned r;
        r = $urandom_range(99);
        if (for_delete && board.held_count != 0 && r < 55)
            return board.held[$urandom_range(board.held_count - 1)];
        if (r < 80)
            return value_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    task automatic run_directed();
        offer_request(KIND_LIST, 32'sd99);
        offer_request(KIND_DELETE, 32'sd7);
        offer_request(KIND_UNUSED, 32'sh7fff_ffff);
        offer_request(KIND_APPEND, 32'sh8000_0000);
        offer_request(KIND_APPEND, 32'sh7fff_ffff);
        offer_request(KIND_APPEND, 32'sd0);
        offer_request(KIND_APPEND, -32'sd1);
        offer_request(KIND_APPEND, 32'sd5);
        offer_request(KIND_APPEND, 32'sd5);
        offer_request(KIND_APPEND, 32'sh5555_5555);
        offer_request(KIND_APPEND, 32'shaaaa_aaaa);
        offer_request(KIND_APPEND, 32'sd123);
        offer_request(KIND_LIST, 32'sd0);
        // Two equal entries: only the lower one goes.
        offer_request(KIND_DELETE, 32'sd5);
        offer_request(KIND_DELETE, 32'sd999);
        offer_request(KIND_DELETE, 32'sh7fff_ffff);
        offer_request(KIND_LIST, -32'sd1);
        offer_request(KIND_DELETE, 32'sh8000_0000);
        offer_request(KIND_DELETE, 32'shaaaa_aaaa);
        offer_request(KIND_LIST, 32'sd0);
    endtask

    // The append share swings every 40 requests so the list keeps filling and draining.
    task automatic run_random(input int count);
        int append_pct;
        int r;
        append_pct = 45;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                append_pct = 25 + 20 * $urandom_range(2);
            r = $urandom_range(99);
            if (r < 4)
                offer_request(KIND_UNUSED, $urandom);
            else if (r < 20)
                offer_request(KIND_LIST, $urandom);
            else if (r < 20 + append_pct)
                offer_request(KIND_APPEND, pick_value(1'b0));
            else
                offer_request(KIND_DELETE, pick_value(1'b1));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 74;
        run_directed();
        run_random(160);

        send_idle_pct = 74;
        recv_idle_pct = 19;
        run_random(160);

        // Sender stays quiet until every outstanding result has been taken.
        cmd_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start = 1'b1;
        repeat (6) offer_request(KIND_APPEND, pick_value(1'b0));
        repeat (12) offer_request(KIND_LIST, $urandom);
        run_random(150);
        cmd_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d results under three idle profiles,",
                 board.requests_seen, board.results_seen);
        $display("a long result hold-off; status counts %0d %0d %0d %0d %0d %0d %0d.",
                 board.status_hits[0], board.status_hits[1], board.status_hits[2],
                 board.status_hits[3], board.status_hits[4], board.status_hits[5],
                 board.status_hits[6]);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[compacting_value_list] OK");
        else
            $display("[compacting_value_list] ERROR");
        $finish;
    end
endmodule
